FILE: rtl/ssp_pkg.sv
// shared types, constants and helpers for the shortest path unit
package ssp_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int VIDX_W       = $clog2(MAX_VERTICES);
   localparam int VCNT_W       = VIDX_W + 1;
   localparam int MAX_EDGES    = 1024;
   localparam int EADDR_W      = $clog2(MAX_EDGES);
   localparam int ECNT_W       = EADDR_W + 1;
   localparam int WEIGHT_BITS  = 16;
   localparam int DIST_W       = 30;
   localparam int CSR_DATA_W   = 7;

   localparam logic [DIST_W-1:0] UNREACHED = DIST_W'(1000000000);

   localparam logic CSR_VERTEX_COUNT  = 1'b0;
   localparam logic CSR_SOURCE_VERTEX = 1'b1;

   localparam logic KIND_EDGE = 1'b0;
   localparam logic KIND_RUN  = 1'b1;

   typedef struct packed {
      logic [WEIGHT_BITS-1:0] weight;
      logic [VIDX_W-1:0]      end_b;
      logic [VIDX_W-1:0]      end_a;
   } edge_type;

   typedef struct packed {
      logic [EADDR_W-1:0] rd_addr;
      logic               clear;
   } edge_ctl_type;

   typedef struct packed {
      edge_type          rd_data;
      logic [ECNT_W-1:0] count;
      logic              dropped;
   } edge_sts_type;

   function automatic logic [VCNT_W-1:0] live_count(input logic [CSR_DATA_W-1:0] vc);
      logic [VCNT_W-1:0] c;
      c = VCNT_W'(vc);
      if (c == '0) c = VCNT_W'(1);
      if (c > VCNT_W'(MAX_VERTICES)) c = VCNT_W'(MAX_VERTICES);
      return c;
   endfunction

endpackage

FILE: rtl/ssp_edge_store.sv
// edge memory with fill count and drop flag
module ssp_edge_store (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  ssp_pkg::edge_type           wr_edge,
   input  logic [ssp_pkg::VCNT_W-1:0]  nv,
   input  ssp_pkg::edge_ctl_type       ctl,
   output ssp_pkg::edge_sts_type       sts
);

   ssp_pkg::edge_type mem [ssp_pkg::MAX_EDGES];
   ssp_pkg::edge_type rd_ff;
   logic [ssp_pkg::ECNT_W-1:0] count_ff, count_in;
   logic dropped_ff, dropped_in;
   logic accept_edge;

   assign accept_edge = (count_ff < ssp_pkg::ECNT_W'(ssp_pkg::MAX_EDGES))
      && (ssp_pkg::VCNT_W'(wr_edge.end_a) < nv)
      && (ssp_pkg::VCNT_W'(wr_edge.end_b) < nv);

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (ctl.clear) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end else if (wr_en) begin
         if (accept_edge) count_in = count_ff + ssp_pkg::ECNT_W'(1);
         else dropped_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && accept_edge) begin
         mem[count_ff[ssp_pkg::EADDR_W-1:0]] <= wr_edge;
      end
      rd_ff <= mem[ctl.rd_addr];
   end

   assign sts.rd_data = rd_ff;
   assign sts.count   = count_ff;
   assign sts.dropped = dropped_ff;

endmodule

FILE: rtl/ssp_engine.sv
// distance memory and search sequencer
module ssp_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ssp_pkg::VCNT_W-1:0]    nv,
   input  logic [ssp_pkg::VIDX_W-1:0]    source,
   input  ssp_pkg::edge_sts_type         edge_sts,
   output ssp_pkg::edge_ctl_type         edge_ctl,
   output logic                          idle,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [ssp_pkg::VIDX_W-1:0]    out_vertex,
   output logic [ssp_pkg::DIST_W-1:0]    out_distance,
   output logic                          out_last,
   output logic                          out_dropped
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_INIT     = 4'd1;
   localparam logic [3:0] ST_SCAN_RD  = 4'd2;
   localparam logic [3:0] ST_SCAN_CMP = 4'd3;
   localparam logic [3:0] ST_SETTLE   = 4'd4;
   localparam logic [3:0] ST_EDGE_RD  = 4'd5;
   localparam logic [3:0] ST_EDGE_CHK = 4'd6;
   localparam logic [3:0] ST_DIST_CHK = 4'd7;
   localparam logic [3:0] ST_OUT_RD   = 4'd8;
   localparam logic [3:0] ST_OUT_LD   = 4'd9;
   localparam logic [3:0] ST_OUT_WAIT = 4'd10;

   localparam int VW = ssp_pkg::VIDX_W;
   localparam int CW = ssp_pkg::VCNT_W;
   localparam int DW = ssp_pkg::DIST_W;
   localparam int EW = ssp_pkg::ECNT_W;

   logic [DW-1:0] mem [ssp_pkg::MAX_VERTICES];
   logic [DW-1:0] rd_ff;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [EW-1:0] eidx_ff, eidx_in;
   logic [ssp_pkg::MAX_VERTICES-1:0] settled_ff, settled_in;
   logic          found_ff, found_in;
   logic [VW-1:0] best_ff, best_in;
   logic [DW-1:0] best_d_ff, best_d_in;
   logic [VW-1:0] to_ff, to_in;
   logic [DW-1:0] cand_ff, cand_in;
   logic          valid_ff, valid_in;
   logic [VW-1:0] vert_ff, vert_in;
   logic [DW-1:0] dist_ff, dist_in;
   logic          last_ff, last_in;
   logic          drop_ff, drop_in;

   logic          wr_en;
   logic [VW-1:0] wr_addr, rd_addr;
   logic [DW-1:0] wr_data;
   logic          take;
   logic [DW:0]   sum;
   ssp_pkg::edge_type ed;

   assign ed  = edge_sts.rd_data;
   assign sum = {1'b0, best_d_ff} + (DW+1)'(ed.weight);

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      eidx_in    = eidx_ff;
      settled_in = settled_ff;
      found_in   = found_ff;
      best_in    = best_ff;
      best_d_in  = best_d_ff;
      to_in      = to_ff;
      cand_in    = cand_ff;
      valid_in   = valid_ff;
      vert_in    = vert_ff;
      dist_in    = dist_ff;
      last_in    = last_ff;
      drop_in    = drop_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff[VW-1:0];
      wr_data    = ssp_pkg::UNREACHED;
      rd_addr    = idx_ff[VW-1:0];
      edge_ctl.rd_addr = eidx_ff[ssp_pkg::EADDR_W-1:0];
      edge_ctl.clear   = 1'b0;
      take       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               idx_in     = '0;
               settled_in = '0;
               state_in   = ST_INIT;
            end
         end
         ST_INIT: begin
            wr_en = 1'b1;
            if (idx_ff[VW-1:0] == source && CW'(source) < nv) wr_data = '0;
            idx_in = idx_ff + CW'(1);
            if (idx_ff == CW'(ssp_pkg::MAX_VERTICES - 1)) begin
               idx_in   = '0;
               found_in = 1'b0;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            take = !settled_ff[idx_ff[VW-1:0]] && rd_ff < ssp_pkg::UNREACHED
               && (!found_ff || rd_ff < best_d_ff);
            if (take) begin
               found_in  = 1'b1;
               best_in   = idx_ff[VW-1:0];
               best_d_in = rd_ff;
            end
            idx_in   = idx_ff + CW'(1);
            state_in = ST_SCAN_RD;
            if (idx_ff == nv - CW'(1)) begin
               idx_in   = '0;
               state_in = (found_ff || take) ? ST_SETTLE : ST_OUT_RD;
            end
         end
         ST_SETTLE: begin
            settled_in[best_ff] = 1'b1;
            eidx_in  = '0;
            found_in = 1'b0;
            state_in = (edge_sts.count == '0) ? ST_SCAN_RD : ST_EDGE_RD;
         end
         ST_EDGE_RD: state_in = ST_EDGE_CHK;
         ST_EDGE_CHK: begin
            cand_in = (sum > (DW+1)'(ssp_pkg::UNREACHED)) ? ssp_pkg::UNREACHED : sum[DW-1:0];
            to_in   = (ed.end_a == best_ff) ? ed.end_b : ed.end_a;
            rd_addr = to_in;
            if (ed.end_a == best_ff || ed.end_b == best_ff) begin
               state_in = ST_DIST_CHK;
            end else begin
               eidx_in  = eidx_ff + EW'(1);
               state_in = (eidx_in == edge_sts.count) ? ST_SCAN_RD : ST_EDGE_RD;
            end
         end
         ST_DIST_CHK: begin
            wr_addr = to_ff;
            wr_data = cand_ff;
            wr_en   = rd_ff > cand_ff;
            eidx_in  = eidx_ff + EW'(1);
            state_in = (eidx_in == edge_sts.count) ? ST_SCAN_RD : ST_EDGE_RD;
         end
         ST_OUT_RD: state_in = ST_OUT_LD;
         ST_OUT_LD: begin
            valid_in = 1'b1;
            vert_in  = idx_ff[VW-1:0];
            dist_in  = rd_ff;
            last_in  = idx_ff == nv - CW'(1);
            drop_in  = edge_sts.dropped;
            state_in = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (out_ready) begin
               valid_in = 1'b0;
               idx_in   = idx_ff + CW'(1);
               if (last_ff) begin
                  edge_ctl.clear = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= 1'b0;
         settled_ff <= '0;
         found_ff   <= 1'b0;
         idx_ff     <= '0;
         eidx_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         settled_ff <= settled_in;
         found_ff   <= found_in;
         idx_ff     <= idx_in;
         eidx_ff    <= eidx_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff   <= best_in;
      best_d_ff <= best_d_in;
      to_ff     <= to_in;
      cand_ff   <= cand_in;
      vert_ff   <= vert_in;
      dist_ff   <= dist_in;
      last_ff   <= last_in;
      drop_ff   <= drop_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   assign idle         = state_ff == ST_IDLE;
   assign out_valid    = valid_ff;
   assign out_vertex   = vert_ff;
   assign out_distance = dist_ff;
   assign out_last     = last_ff;
   assign out_dropped  = drop_ff;

endmodule

FILE: rtl/single_source_shortest_path_unit.sv
// edge item: accepted while idle, no result; next request may follow at once
// run item: init of all 64 distances, then per settled vertex an nv-entry scan, a settle
// step, a read, check and maybe relax per stored edge, a closing scan, then each vertex out
// throughput bound by the sequential distance memory walk, one request at a time
// reset is synchronous: clears the sequencer, edge count, drop flag, registers
// edge memory contents stay undefined; distances are rebuilt by every run
module single_source_shortest_path_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // end_a, end_b, weight, zero pad
   input  logic        req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // vertex, distance, zero pad
   output logic        rsp_tlast,
   output logic        rsp_tuser,  // edges_dropped
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata
);

   logic [ssp_pkg::CSR_DATA_W-1:0] vcount_ff;
   logic [ssp_pkg::VIDX_W-1:0]     source_ff;
   logic [ssp_pkg::VCNT_W-1:0]     nv;
   logic                           idle, accept;
   ssp_pkg::edge_type              wr_edge;
   ssp_pkg::edge_ctl_type          edge_ctl;
   ssp_pkg::edge_sts_type          edge_sts;
   logic [ssp_pkg::VIDX_W-1:0]     out_vertex;
   logic [ssp_pkg::DIST_W-1:0]     out_distance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= ssp_pkg::CSR_DATA_W'(ssp_pkg::MAX_VERTICES);
         source_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == ssp_pkg::CSR_VERTEX_COUNT) vcount_ff <= csr_wdata;
         else source_ff <= csr_wdata[ssp_pkg::VIDX_W-1:0];
      end
   end

   assign nv         = ssp_pkg::live_count(vcount_ff);
   assign req_tready = idle;
   assign accept     = req_tvalid && idle;

   assign wr_edge.end_a  = req_tdata[5:0];
   assign wr_edge.end_b  = req_tdata[11:6];
   assign wr_edge.weight = req_tdata[12 +: ssp_pkg::WEIGHT_BITS];

   ssp_edge_store u_edges (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && req_tuser == ssp_pkg::KIND_EDGE),
      .wr_edge (wr_edge),
      .nv      (nv),
      .ctl     (edge_ctl),
      .sts     (edge_sts)
   );

   ssp_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .start        (accept && req_tuser == ssp_pkg::KIND_RUN),
      .nv           (nv),
      .source       (source_ff),
      .edge_sts     (edge_sts),
      .edge_ctl     (edge_ctl),
      .idle         (idle),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_vertex   (out_vertex),
      .out_distance (out_distance),
      .out_last     (rsp_tlast),
      .out_dropped  (rsp_tuser)
   );

   assign rsp_tdata = {4'd0, out_distance, out_vertex};

endmodule

FILE: rtl/ssp_checker.sv
// port-level checks for the shortest path unit
module ssp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while response pending");

   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("not idle after last response");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[35:6] <= 30'd1000000000)
      else $error("distance out of range");

endmodule

bind single_source_shortest_path_unit ssp_checker u_ssp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
